// File: rtl/spg_pkg.sv
// Shared constants and types for the sine plasma pixel generator.
// No dependencies.
package spg_pkg;

  localparam int PhaseW     = 16;
  localparam int ProdW      = 25;    // gx * phase_per_pixel
  localparam int SqW        = 52;    // fx^2 + fy^2 with headroom
  localparam int RootW      = 26;
  localparam int SqrtStages = RootW / 2;
  localparam int Layers     = 4;

  localparam logic [8:0]  K1p3     = 9'd333;
  localparam logic [8:0]  K0p7     = 9'd179;
  localparam logic [14:0] OneQ14   = 15'd16384;
  localparam logic [14:0] SinA     = 15'd25736;
  localparam logic [13:0] SinB     = 14'd10512;
  localparam logic [10:0] SinC     = 11'd1160;
  localparam logic [18:0] Div3Mul  = 19'd349526;  // ceil(2^20 / 3)

  typedef enum logic [2:0] {
    RegPhasePerPixel = 3'd0,
    RegLayerCount    = 3'd1,
    RegColorLow      = 3'd2,
    RegColorMid      = 3'd3,
    RegColorHigh     = 3'd4,
    RegOriginX       = 3'd5,
    RegOriginY       = 3'd6,
    RegEnable        = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [10:0] sx;
    logic [10:0] sy;
  } coord_t;

  typedef struct packed {
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [14:0] th;
    coord_t      xy;
  } carry_t;

endpackage

// File: rtl/sine_plasma_pixel_generator.sv
// Sine plasma pixel generator: fully pipelined, one pixel per clock.
// Depends on spg_pkg.
//
// Channel   Direction  Handshake                 Payload
// command   in         start (busy always low)   pixel_x_i, pixel_y_i, time_phase_i
// config    in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
// result    out        result_strobe_o (1 cycle) screen_x_o, screen_y_o, red_o..blue_o
//
// A pixel can be started every cycle; pixels outside the area or while disabled are
// dropped at entry. The pipeline runs through the 13-stage square root (two root bits
// per stage) and the 4-multiply sine evaluation. Reset clears all valid bits and
// loads the register defaults. The receiver cannot stall, so the pipeline never holds.
module sine_plasma_pixel_generator #(
  parameter int WIDTH           = 320,
  parameter int HEIGHT          = 240,
  parameter int BLOCK_SIZE      = 4,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [9:0]              pixel_x_i,
  input  logic [9:0]              pixel_y_i,
  input  logic [15:0]             time_phase_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  spg_pkg::cfg_reg_e       cfg_index_i,
  input  logic [23:0]             cfg_data_i,
  output logic                    result_strobe_o,
  output logic [10:0]             screen_x_o,
  output logic [10:0]             screen_y_o,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o
);
  import spg_pkg::*;

  // floor(p / BLOCK_SIZE) as (p * BlkMul) >> 20, exact for p < 2^16
  localparam logic [20:0] BlkMul    = 21'((2**20 + BLOCK_SIZE - 1) / BLOCK_SIZE);
  localparam logic [16:0] PhaseStep = 17'd1 << (PhaseW - SINE_TABLE_BITS);
  localparam logic [15:0] PhaseMask = 16'(17'h10000 - PhaseStep);

  // ---------------- configuration registers ----------------
  logic [13:0] ppp_q;
  logic [2:0]  layers_q;
  logic [23:0] col_lo_q, col_mid_q, col_hi_q;
  logic [9:0]  org_x_q, org_y_q;
  logic        en_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppp_q     <= 14'd695;
      layers_q  <= 3'd3;
      col_lo_q  <= 24'd16711680;
      col_mid_q <= 24'd1981695;
      col_hi_q  <= 24'd16768030;
      org_x_q   <= '0;
      org_y_q   <= '0;
      en_q      <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegPhasePerPixel: ppp_q     <= cfg_data_i[13:0];
        RegLayerCount:    layers_q  <= cfg_data_i[2:0];
        RegColorLow:      col_lo_q  <= cfg_data_i;
        RegColorMid:      col_mid_q <= cfg_data_i;
        RegColorHigh:     col_hi_q  <= cfg_data_i;
        RegOriginX:       org_x_q   <= cfg_data_i[9:0];
        RegOriginY:       org_y_q   <= cfg_data_i[9:0];
        RegEnable:        en_q      <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // clamped layer count, 1..4
  logic [2:0] n_c;
  assign n_c = (layers_q == 3'd0) ? 3'd1 : ((layers_q > 3'd4) ? 3'd4 : layers_q);

  // ---------------- front end: block floor, origin, scaling ----------------
  logic        v1_q, v2_q, v3_q;
  logic [9:0]  qx1_q, qy1_q;
  logic [10:0] gx2_q, gy2_q;
  logic [24:0] fx3_q, fy3_q;
  logic [15:0] t1_q, t2_q, t3_q;
  coord_t      xy1_q, xy2_q, xy3_q;
  logic        in_ok;

  assign in_ok = start && en_q && (32'(pixel_x_i) < 32'(WIDTH))
              && (32'(pixel_y_i) < 32'(HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_ok;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    qx1_q    <= 10'((31'(pixel_x_i) * 31'(BlkMul)) >> 20);
    qy1_q    <= 10'((31'(pixel_y_i) * 31'(BlkMul)) >> 20);
    t1_q     <= time_phase_i;
    xy1_q.sx <= 11'(pixel_x_i) + 11'(org_x_q);
    xy1_q.sy <= 11'(pixel_y_i) + 11'(org_y_q);

    gx2_q <= 11'(10'(20'(qx1_q) * 20'(BLOCK_SIZE))) + 11'(org_x_q);
    gy2_q <= 11'(10'(20'(qy1_q) * 20'(BLOCK_SIZE))) + 11'(org_y_q);
    t2_q  <= t1_q;
    xy2_q <= xy1_q;

    fx3_q <= 25'(gx2_q) * 25'(ppp_q);
    fy3_q <= 25'(gy2_q) * 25'(ppp_q);
    t3_q  <= t2_q;
    xy3_q <= xy2_q;
  end

  // ---------------- layer phases and square-root input ----------------
  logic [SqW-1:0]   rem_q  [0:SqrtStages];
  logic [RootW-1:0] root_q [0:SqrtStages];
  carry_t           cc_q   [0:SqrtStages];
  logic             cv_q   [0:SqrtStages];
  carry_t           c4_d;
  logic [23:0]      fxy_sum, l2_acc, l3_acc;

  always_comb begin
    fxy_sum  = 24'(fx3_q) + 24'(fy3_q);
    l2_acc   = 24'(fy3_q) * 24'(K1p3) + 24'(t3_q) * 24'(K0p7);
    l3_acc   = fxy_sum * 24'(K0p7) + 24'(t3_q) * 24'(K1p3);
    c4_d.p1  = fx3_q[15:0] + t3_q;
    c4_d.p2  = l2_acc[23:8];
    c4_d.p3  = l3_acc[23:8];
    c4_d.th  = t3_q[15:1];
    c4_d.xy  = xy3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else begin
      cv_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= SqW'(50'(fx3_q) * 50'(fx3_q)) + SqW'(50'(fy3_q) * 50'(fy3_q));
    root_q[0] <= '0;
    cc_q[0]   <= c4_d;
  end

  // digit-by-digit root, two bits per stage; invariant rem = v - root^2
  for (genvar k = 0; k < SqrtStages; k++) begin : g_sqrt
    localparam int B1 = RootW - 1 - 2 * k;
    localparam int B0 = B1 - 1;
    logic [SqW-1:0]   d1, d0, r1, r0;
    logic [RootW-1:0] rt1, rt0;

    always_comb begin
      d1 = (SqW'(root_q[k]) << (B1 + 1)) + (SqW'(1) << (2 * B1));
      if (rem_q[k] >= d1) begin
        r1  = rem_q[k] - d1;
        rt1 = root_q[k] | (RootW'(1) << B1);
      end else begin
        r1  = rem_q[k];
        rt1 = root_q[k];
      end
      d0 = (SqW'(rt1) << (B0 + 1)) + (SqW'(1) << (2 * B0));
      if (r1 >= d0) begin
        r0  = r1 - d0;
        rt0 = rt1 | (RootW'(1) << B0);
      end else begin
        r0  = r1;
        rt0 = rt1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k+1] <= 1'b0;
      end else begin
        cv_q[k+1] <= cv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= r0;
      root_q[k+1] <= rt0;
      cc_q[k+1]   <= cc_q[k];
    end
  end

  // ---------------- sine lanes ----------------
  logic [15:0] ph [Layers];
  logic [15:0] phq [Layers];
  logic [14:0] za_q [Layers], zb_q [Layers], zc_q [Layers], zd_q [Layers];
  logic        na_q [Layers], nb_q [Layers], nc_q [Layers], nd_q [Layers];
  logic [14:0] z2b_q [Layers], z2c_q [Layers];
  logic [13:0] inner_q [Layers];
  logic [14:0] outer_q [Layers];
  logic signed [15:0] sv_q [Layers];
  logic [14:0] mag [Layers];
  logic        va_q, vb_q, vc_q, vd_q, ve_q;
  coord_t      xya_q, xyb_q, xyc_q, xyd_q, xye_q;

  always_comb begin
    ph[0] = cc_q[SqrtStages].p1;
    ph[1] = cc_q[SqrtStages].p2;
    ph[2] = cc_q[SqrtStages].p3;
    ph[3] = root_q[SqrtStages][15:0] + 16'(cc_q[SqrtStages].th);
    for (int l = 0; l < Layers; l++) begin
      phq[l] = ph[l] & PhaseMask;
      mag[l] = 15'((30'(zd_q[l]) * 30'(outer_q[l])) >> 14);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      va_q <= cv_q[SqrtStages];
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < Layers; l++) begin
      // odd quadrants mirror the quarter wave, upper half negates
      za_q[l]    <= phq[l][14] ? (OneQ14 - 15'(phq[l][13:0])) : 15'(phq[l][13:0]);
      na_q[l]    <= phq[l][15];
      z2b_q[l]   <= 15'((30'(za_q[l]) * 30'(za_q[l])) >> 14);
      zb_q[l]    <= za_q[l];
      nb_q[l]    <= na_q[l];
      inner_q[l] <= SinB - 14'((26'(z2b_q[l]) * 26'(SinC)) >> 14);
      z2c_q[l]   <= z2b_q[l];
      zc_q[l]    <= zb_q[l];
      nc_q[l]    <= nb_q[l];
      outer_q[l] <= SinA - 15'((29'(z2c_q[l]) * 29'(inner_q[l])) >> 14);
      zd_q[l]    <= zc_q[l];
      nd_q[l]    <= nc_q[l];
      sv_q[l]    <= nd_q[l] ? -$signed(16'(mag[l])) : $signed(16'(mag[l]));
    end
    xya_q <= cc_q[SqrtStages].xy;
    xyb_q <= xya_q;
    xyc_q <= xyb_q;
    xyd_q <= xyc_q;
    xye_q <= xyd_q;
  end

  // ---------------- sum, normalize, blend ----------------
  logic signed [18:0] sum_c;
  logic [17:0]        w_q;
  logic [18:0]        x2;
  logic [37:0]        x3_prod;
  logic [18:0]        vq;
  logic [16:0]        v16_q;
  logic [8:0]         t8_q;
  logic [23:0]        ca_q, cb_q;
  logic               vf_q, vg_q, vh_q;
  coord_t             xyf_q, xyg_q, xyh_q;

  always_comb begin
    sum_c = 19'(n_c) * 19'(OneQ14);
    for (int l = 0; l < Layers; l++) begin
      if (3'(l) < n_c) begin
        sum_c = sum_c + 19'(sv_q[l]);
      end
    end
    x2      = {w_q, 1'b0};
    x3_prod = 38'(x2) * 38'(Div3Mul);
    case (n_c)
      3'd1:    vq = x2;
      3'd2:    vq = x2 >> 1;
      3'd3:    vq = 19'(x3_prod >> 20);
      default: vq = x2 >> 2;
    endcase
  end

  function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b, logic [8:0] t);
    logic [16:0] acc;
    acc = 17'(a) * 17'(9'd256 - t) + 17'(b) * 17'(t);
    return acc[15:8];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q            <= 1'b0;
      vg_q            <= 1'b0;
      vh_q            <= 1'b0;
      result_strobe_o <= 1'b0;
    end else begin
      vf_q            <= ve_q;
      vg_q            <= vf_q;
      vh_q            <= vg_q;
      result_strobe_o <= vh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= 18'(sum_c);
    xyf_q <= xye_q;

    v16_q <= (vq > 19'd65536) ? 17'd65536 : 17'(vq);
    xyg_q <= xyf_q;

    if (v16_q < 17'd32768) begin
      t8_q <= 9'(v16_q >> 7);
      ca_q <= col_lo_q;
      cb_q <= col_mid_q;
    end else begin
      t8_q <= 9'((v16_q - 17'd32768) >> 7);
      ca_q <= col_mid_q;
      cb_q <= col_hi_q;
    end
    xyh_q <= xyg_q;

    screen_x_o <= xyh_q.sx;
    screen_y_o <= xyh_q.sy;
    red_o      <= blend(ca_q[23:16], cb_q[23:16], t8_q);
    green_o    <= blend(ca_q[15:8],  cb_q[15:8],  t8_q);
    blue_o     <= blend(ca_q[7:0],   cb_q[7:0],   t8_q);
  end

endmodule
